@@ hw/rtl/sdbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbl_pkg
// Shared types and constants of the sorted descending byte list.
// ----------------------------------------------------------------------------
package sdbl_pkg;

    localparam int DEPTH   = 32;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int VAL_W   = 8;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;
    localparam int CMP_W   = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_READ   = 3'd2,
        KIND_EVENS  = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM_FIND,
        S_REM_SHIFT,
        S_READ,
        S_EVEN,
        S_SMALL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [COUNT_W-1:0]      count;
        logic                    empty_res;
        logic signed [VAL_W-1:0] smallest;
    } t_out;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [AW-1:0]    raddr;
    } t_ram_req;

endpackage

@@ hw/rtl/sorted_descending_byte_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_byte_list
// Up to DEPTH signed bytes kept in descending order in one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready/i_in) carries one operation: insert,
//   remove value, read position, remove evens or clear. Output channel
//   (o_valid/i_ready/o_out) returns exactly one result per operation.
//   One operation is handled at a time. The sequencer walks the entry RAM
//   one entry per cycle (one read port, registered read data), then reads
//   the last entry to report the smallest value; the result then passes
//   through the output register.
//   Reset empties the list; RAM contents are not cleared and need no pass.
//   The output register frees the sequencer while a result waits; if the
//   receiver stalls, the next result is held and no further input is taken.
// ----------------------------------------------------------------------------
module sorted_descending_byte_list (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sdbl_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output sdbl_pkg::t_out o_out
);
    import sdbl_pkg::*;

    t_ram_req          w_ram;
    logic [VAL_W-1:0]  w_rdata;
    logic              w_res_valid;
    logic              w_res_ready;
    t_out              w_res;

    logic              r_out_valid, n_out_valid;
    t_out              r_out;

    sdbl_ram #(
        .DATA_W (VAL_W),
        .ADDR_W (AW),
        .DEPTH  (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    sdbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in        (i_in),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("sequencer took an item while busy");

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_res_ready |=> w_res_valid && $stable(w_res))
        else $error("internal result dropped while stalled");

    a_empty_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.empty_res |-> o_out.smallest == '0)
        else $error("empty list reports nonzero smallest");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.read_value != '0) |-> o_out.ok)
        else $error("read value without success");

endmodule

@@ hw/rtl/sdbl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbl_ram
// Simple dual-port RAM, registered read, write-first on address match.
// ----------------------------------------------------------------------------
module sdbl_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 5,
    parameter int DEPTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sdbl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbl_ctrl
// Sequencer: walks the entry RAM one entry per cycle, shifting in place.
// ----------------------------------------------------------------------------
module sdbl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sdbl_pkg::t_in     i_in,
    output sdbl_pkg::t_ram_req o_ram,
    input  logic [sdbl_pkg::VAL_W-1:0] i_rdata,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sdbl_pkg::t_out    o_res
);
    import sdbl_pkg::*;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_kept, n_kept;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic                    r_ok, n_ok;
    logic signed [VAL_W-1:0] r_rd, n_rd;
    logic signed [VAL_W-1:0] r_small, n_small;

    logic                    w_fin;
    logic [CW-1:0]           w_fin_cnt;
    logic                    w_last;
    logic [CW-1:0]           w_kept_next;
    logic signed [VAL_W-1:0] w_rdata;

    assign w_rdata     = $signed(i_rdata);
    assign w_last      = ((CW'(r_idx) + CW'(1)) == r_cnt);
    assign w_kept_next = r_kept + CW'(i_rdata[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_kept  <= n_kept;
        r_val   <= n_val;
        r_ok    <= n_ok;
        r_rd    <= n_rd;
        r_small <= n_small;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_val       = r_val;
        n_ok        = r_ok;
        n_rd        = r_rd;
        n_small     = r_small;
        o_ram       = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        w_fin       = 1'b0;
        w_fin_cnt   = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_val = i_in.value;
                    n_ok  = 1'b0;
                    n_rd  = '0;
                    case (i_in.kind)
                        KIND_INSERT: begin
                            if (r_cnt >= CW'(DEPTH)) begin
                                w_fin = 1'b1;
                            end else if (r_cnt == '0) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = '0;
                                o_ram.wdata = i_in.value;
                                n_ok        = 1'b1;
                                w_fin       = 1'b1;
                                w_fin_cnt   = CW'(1);
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = AW'(r_cnt - CW'(1));
                                n_idx       = AW'(r_cnt - CW'(1));
                                n_state     = S_INS;
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_cnt == '0) begin
                                w_fin = 1'b1;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_REM_FIND;
                            end
                        end
                        KIND_READ: begin
                            if (CMP_W'(i_in.position) < CMP_W'(r_cnt)) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = AW'(i_in.position);
                                n_state     = S_READ;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        KIND_EVENS: begin
                            if (r_cnt == '0) begin
                                w_fin = 1'b1;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = '0;
                                n_idx       = '0;
                                n_kept      = '0;
                                n_state     = S_EVEN;
                            end
                        end
                        KIND_CLEAR: begin
                            n_ok      = 1'b1;
                            w_fin     = 1'b1;
                            w_fin_cnt = '0;
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx + AW'(1);
                if (w_rdata < r_val) begin
                    o_ram.wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_idx - AW'(1);
                        n_idx       = r_idx - AW'(1);
                    end
                end else begin
                    o_ram.wdata = r_val;
                    n_ok        = 1'b1;
                    w_fin       = 1'b1;
                    w_fin_cnt   = r_cnt + CW'(1);
                end
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = '0;
                o_ram.wdata = r_val;
                n_ok        = 1'b1;
                w_fin       = 1'b1;
                w_fin_cnt   = r_cnt + CW'(1);
            end
            S_REM_FIND: begin
                priority if (w_rdata > r_val) begin
                    if (w_last) begin
                        w_fin = 1'b1;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_idx + AW'(1);
                        n_idx       = r_idx + AW'(1);
                    end
                end else if (w_rdata == r_val) begin
                    if (w_last) begin
                        n_ok      = 1'b1;
                        w_fin     = 1'b1;
                        w_fin_cnt = r_cnt - CW'(1);
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_idx + AW'(1);
                        n_idx       = r_idx + AW'(1);
                        n_state     = S_REM_SHIFT;
                    end
                end else begin
                    w_fin = 1'b1;
                end
            end
            S_REM_SHIFT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx - AW'(1);
                o_ram.wdata = i_rdata;
                if (w_last) begin
                    n_ok      = 1'b1;
                    w_fin     = 1'b1;
                    w_fin_cnt = r_cnt - CW'(1);
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_idx + AW'(1);
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_READ: begin
                n_rd  = w_rdata;
                n_ok  = 1'b1;
                w_fin = 1'b1;
            end
            S_EVEN: begin
                if (i_rdata[0]) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = AW'(r_kept);
                    o_ram.wdata = i_rdata;
                end
                n_kept = w_kept_next;
                if (w_last) begin
                    n_ok      = 1'b1;
                    w_fin     = 1'b1;
                    w_fin_cnt = w_kept_next;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_idx + AW'(1);
                    n_idx       = r_idx + AW'(1);
                end
            end
            S_SMALL: begin
                n_small = w_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // fetch the last entry for the smallest value
        if (w_fin) begin
            n_cnt = w_fin_cnt;
            if (w_fin_cnt != '0) begin
                o_ram.re    = 1'b1;
                o_ram.raddr = AW'(w_fin_cnt - CW'(1));
                n_state     = S_SMALL;
            end else begin
                n_small = '0;
                n_state = S_DONE;
            end
        end
    end

    assign o_res.ok         = r_ok;
    assign o_res.read_value = r_rd;
    assign o_res.count      = COUNT_W'(r_cnt);
    assign o_res.empty_res  = (r_cnt == '0);
    assign o_res.smallest   = r_small;

endmodule
